// ===== hdl/assert_macros.svh =====
// Assertion macros included by the RTL core of the microlens center locator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, quiet during reset.
`define MLCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define MLCL_ASSERT_IMP(lbl, ante, cons, msg) \
  `MLCL_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define MLCL_ASSERT_NXT(lbl, ante, cons, msg) \
  `MLCL_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hdl/mlcl_pkg.sv =====
// Package with constants, register codes and helpers of the microlens center locator.
`timescale 1ns / 1ps
package mlcl_pkg;

  localparam int unsigned SensorWidth  = 7728;
  localparam int unsigned SensorHeight = 5368;
  localparam int unsigned MaxLenses    = 1024;
  localparam int unsigned FracBits     = 8;

  localparam int unsigned IdxW    = 10;
  localparam int unsigned CntW    = 11;
  localparam int unsigned PixW    = 13;
  localparam int unsigned CoordW  = 22;
  localparam int unsigned CornerW = 2 * CoordW;
  localparam int unsigned PitchW  = 16;
  localparam int unsigned WeightW = 2 * IdxW;
  localparam int unsigned ProdW   = WeightW + 1 + CoordW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned NumW    = WeightW + CoordW;
  localparam int unsigned QuotW   = CoordW;
  localparam int unsigned PosW    = CoordW + 2;
  localparam int unsigned DataW   = 64;
  localparam int unsigned AddrW   = 6;

  typedef enum logic [2:0] {
    RegCornerTl   = 3'd0,
    RegCornerTr   = 3'd1,
    RegCornerBl   = 3'd2,
    RegCornerBr   = 3'd3,
    RegLensCols   = 3'd4,
    RegLensRows   = 3'd5,
    RegHalfPitch  = 3'd6
  } reg_idx_e;

  // Last valid index for a lens count, with the count saturated to [2, MaxLenses].
  function automatic logic [IdxW-1:0] last_index(input logic [CntW-1:0] n);
    logic [IdxW-1:0] res;
    if (n < CntW'(2)) begin
      res = IdxW'(1);
    end else if (n > CntW'(MaxLenses)) begin
      res = IdxW'(MaxLenses - 1);
    end else begin
      res = IdxW'(n - CntW'(1));
    end
    return res;
  endfunction

endpackage

// ===== hdl/mlcl_if.sv =====
// Handshake interfaces for the lens index words and the pixel position words.
`timescale 1ns / 1ps
interface mlcl_in_if;
  import mlcl_pkg::*;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] lens_col;
  logic [IdxW-1:0] lens_row;
  modport source (output valid, lens_col, lens_row, input ready);
  modport sink   (input valid, lens_col, lens_row, output ready);
endinterface

interface mlcl_out_if;
  import mlcl_pkg::*;
  logic                valid;
  logic                ready;
  logic [PixW-1:0]     pixel_col;
  logic [PixW-1:0]     pixel_row;
  logic [FracBits-1:0] frac_x;
  logic [FracBits-1:0] frac_y;
  logic                inside_res;
  modport source (output valid, pixel_col, pixel_row, frac_x, frac_y, inside_res,
                  input ready);
  modport sink   (input valid, pixel_col, pixel_row, frac_x, frac_y, inside_res,
                  output ready);
endinterface

// ===== hdl/microlens_center_locator_core.sv =====
// Top level of the microlens center locator: APB registers and the position pipeline.
//
//   channel   | dir | handshake     | word
//   item_i    | in  | valid/ready   | lens_col, lens_row
//   result_o  | out | valid/ready   | pixel_col, pixel_row, frac_x, frac_y, inside_res
//   APB       | in  | psel/penable  | 64-bit register data, pready always high
//
// One word enters per clock unless the output word waits; it passes the clamp, weight, product and
// sum stages, the 22-stage restoring divider (one quotient bit per stage) and the final stage.
// The whole pipeline advances together; it halts only while the output word waits.
// rst_ni clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
module microlens_center_locator_core
  import mlcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready,
  mlcl_in_if.sink            item_i,
  mlcl_out_if.source         result_o
);

  localparam int unsigned PreStg = 4;
  localparam int unsigned Lat    = PreStg + QuotW + 1;
  localparam logic [PosW-1:0] XMax = PosW'((SensorWidth - 1) * (1 << FracBits));
  localparam logic [PosW-1:0] YMax = PosW'((SensorHeight - 1) * (1 << FracBits));
  localparam logic signed [PosW-1:0] Bias = PosW'(1 << (CoordW - 1));

  // Configuration registers.
  logic [CornerW-1:0] tl_q, tr_q, bl_q, br_q;
  logic [CntW-1:0]    cols_q, rows_q;
  logic [PitchW-1:0]  pitch_q;
  logic               wr_en;
  reg_idx_e           wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wr_idx = reg_idx_e'(paddr[AddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q    <= '0;
      tr_q    <= '0;
      bl_q    <= '0;
      br_q    <= '0;
      cols_q  <= CntW'(2);
      rows_q  <= CntW'(2);
      pitch_q <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        RegCornerTl:  tl_q    <= pwdata[CornerW-1:0];
        RegCornerTr:  tr_q    <= pwdata[CornerW-1:0];
        RegCornerBl:  bl_q    <= pwdata[CornerW-1:0];
        RegCornerBr:  br_q    <= pwdata[CornerW-1:0];
        RegLensCols:  cols_q  <= pwdata[CntW-1:0];
        RegLensRows:  rows_q  <= pwdata[CntW-1:0];
        RegHalfPitch: pitch_q <= pwdata[PitchW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      RegCornerTl:  prdata = DataW'(tl_q);
      RegCornerTr:  prdata = DataW'(tr_q);
      RegCornerBl:  prdata = DataW'(bl_q);
      RegCornerBr:  prdata = DataW'(br_q);
      RegLensCols:  prdata = DataW'(cols_q);
      RegLensRows:  prdata = DataW'(rows_q);
      RegHalfPitch: prdata = DataW'(pitch_q);
      default:      prdata = '0;
    endcase
  end

  // Pipeline control.
  logic           adv;
  logic [Lat-1:0] vld_q;
  logic [Lat-2:0] odd_q;

  assign adv          = !vld_q[Lat-1] || result_o.ready;
  assign item_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], item_i.valid};
    end
  end

  // Stage 1: clamp counts and indices.
  logic [IdxW-1:0] w_d, h_d, c_d, r_d;
  logic [IdxW-1:0] w_q, h_q, c_q, r_q, wc_q, hr_q;

  assign w_d = last_index(cols_q);
  assign h_d = last_index(rows_q);
  assign c_d = (item_i.lens_col > w_d) ? w_d : item_i.lens_col;
  assign r_d = (item_i.lens_row > h_d) ? h_d : item_i.lens_row;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q   <= w_d;
      h_q   <= h_d;
      c_q   <= c_d;
      r_q   <= r_d;
      wc_q  <= w_d - c_d;
      hr_q  <= h_d - r_d;
      odd_q <= {odd_q[Lat-3:0], r_d[0]};
    end
  end

  // Stage 2: corner weights and the common denominator.
  logic [WeightW-1:0] wa_q, wb_q, wc2_q, wd_q, den2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wa_q   <= wc_q * hr_q;
      wb_q   <= c_q * hr_q;
      wc2_q  <= wc_q * r_q;
      wd_q   <= c_q * r_q;
      den2_q <= w_q * h_q;
    end
  end

  // Stage 3: weighted corners.
  logic signed [CoordW-1:0] tlx, trx, blx, brx, tly, try_c, bly, bry;
  logic signed [ProdW-1:0]  px_q [4];
  logic signed [ProdW-1:0]  py_q [4];
  logic [WeightW-1:0]       den3_q;

  assign tlx   = $signed(tl_q[CoordW-1:0]);
  assign trx   = $signed(tr_q[CoordW-1:0]);
  assign blx   = $signed(bl_q[CoordW-1:0]);
  assign brx   = $signed(br_q[CoordW-1:0]);
  assign tly   = $signed(tl_q[CornerW-1:CoordW]);
  assign try_c = $signed(tr_q[CornerW-1:CoordW]);
  assign bly   = $signed(bl_q[CornerW-1:CoordW]);
  assign bry   = $signed(br_q[CornerW-1:CoordW]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q[0] <= $signed({1'b0, wa_q}) * tlx;
      px_q[1] <= $signed({1'b0, wb_q}) * trx;
      px_q[2] <= $signed({1'b0, wc2_q}) * blx;
      px_q[3] <= $signed({1'b0, wd_q}) * brx;
      py_q[0] <= $signed({1'b0, wa_q}) * tly;
      py_q[1] <= $signed({1'b0, wb_q}) * try_c;
      py_q[2] <= $signed({1'b0, wc2_q}) * bly;
      py_q[3] <= $signed({1'b0, wd_q}) * bry;
      den3_q  <= den2_q;
    end
  end

  // Stage 4: sum and bias so that the dividend is never negative; the biased
  // quotient then equals the floor quotient plus half the coordinate range.
  logic signed [SumW-1:0] bias_s, sum_x, sum_y;
  logic [NumW-1:0]        numx_q, numy_q;
  logic [WeightW-1:0]     den4_q;

  assign bias_s = $signed({{(SumW - WeightW - CoordW + 1){1'b0}}, den3_q,
                           {(CoordW - 1){1'b0}}});
  assign sum_x  = SumW'(px_q[0]) + SumW'(px_q[1]) + SumW'(px_q[2]) + SumW'(px_q[3]) + bias_s;
  assign sum_y  = SumW'(py_q[0]) + SumW'(py_q[1]) + SumW'(py_q[2]) + SumW'(py_q[3]) + bias_s;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx_q <= sum_x[NumW-1:0];
      numy_q <= sum_y[NumW-1:0];
      den4_q <= den3_q;
    end
  end

  // Stages 5 to 26: division.
  logic [QuotW-1:0] qx, qy;

  mlcl_div_pipe #(.NW(NumW), .DW(WeightW), .QW(QuotW)) u_div_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (numx_q),
    .den_i  (den4_q),
    .quot_o (qx)
  );

  mlcl_div_pipe #(.NW(NumW), .DW(WeightW), .QW(QuotW)) u_div_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (numy_q),
    .den_i  (den4_q),
    .quot_o (qy)
  );

  // Final stage: remove bias, add the odd-row shift, range check.
  logic signed [PosW-1:0] xs, ys, shift_s;
  logic                   on_sensor;
  logic [PixW-1:0]        pcol_q, prow_q;
  logic [FracBits-1:0]    fx_q, fy_q;
  logic                   in_q;

  assign shift_s   = odd_q[Lat-2] ? $signed({{(PosW - PitchW){1'b0}}, pitch_q}) : '0;
  assign xs        = $signed({2'b00, qx}) - Bias + shift_s;
  assign ys        = $signed({2'b00, qy}) - Bias;
  assign on_sensor = !xs[PosW-1] && ($unsigned(xs) <= XMax)
                  && !ys[PosW-1] && ($unsigned(ys) <= YMax);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q   <= on_sensor;
      pcol_q <= on_sensor ? xs[FracBits+PixW-1:FracBits] : '0;
      prow_q <= on_sensor ? ys[FracBits+PixW-1:FracBits] : '0;
      fx_q   <= on_sensor ? xs[FracBits-1:0] : '0;
      fy_q   <= on_sensor ? ys[FracBits-1:0] : '0;
    end
  end

  assign result_o.valid      = vld_q[Lat-1];
  assign result_o.pixel_col  = pcol_q;
  assign result_o.pixel_row  = prow_q;
  assign result_o.frac_x     = fx_q;
  assign result_o.frac_y     = fy_q;
  assign result_o.inside_res = in_q;

`include "assert_macros.svh"

  `MLCL_ASSERT_NXT(a_accept_enters, item_i.valid && item_i.ready, vld_q[0], "accepted word did not enter stage one")
  `MLCL_ASSERT_IMP(a_outside_zero, result_o.valid && !result_o.inside_res, (result_o.pixel_col == '0) && (result_o.pixel_row == '0) && (result_o.frac_x == '0) && (result_o.frac_y == '0), "outside word carries nonzero position")
  `MLCL_ASSERT_IMP(a_col_range, result_o.valid && result_o.inside_res, result_o.pixel_col <= PixW'(SensorWidth - 1), "pixel column beyond sensor")
  `MLCL_ASSERT_IMP(a_row_range, result_o.valid && result_o.inside_res, result_o.pixel_row <= PixW'(SensorHeight - 1), "pixel row beyond sensor")

endmodule

// ===== hdl/mlcl_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module mlcl_div_pipe
  import mlcl_pkg::*;
#(
  parameter int unsigned NW = NumW,
  parameter int unsigned DW = WeightW,
  parameter int unsigned QW = QuotW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quot_o
);

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned Bit = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [NW-1:0] shifted;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign shifted = NW'(den_in) << Bit;
    assign ge      = (rem_in >= shifted);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (rem_in - shifted) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= quo_in | (QW'(ge) << Bit);
      end
    end
  end

  assign quot_o = quo_q[QW-1];

endmodule

// ===== tb/microlens_center_locator_core_tb.sv =====
// Self-checking testbench of the microlens center locator: directed table, random phases.
`timescale 1ns / 1ps
module microlens_center_locator_core_tb;
  import mlcl_pkg::*;

  localparam int unsigned Latency   = 27;
  localparam int unsigned StallLim  = 3000;
  localparam int unsigned HoldLen   = 200;
  localparam int unsigned NumPhases = 20;

  typedef struct packed {
    logic [PixW-1:0]     pcol;
    logic [PixW-1:0]     prow;
    logic [FracBits-1:0] fx;
    logic [FracBits-1:0] fy;
    logic                ins;
  } lens_pos_t;

  typedef struct {
    int unsigned     step;
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] row;
    bit              typed;
    lens_pos_t       pos;
  } lens_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;

  mlcl_in_if  item_i ();
  mlcl_out_if result_o ();

  microlens_center_locator_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (item_i.sink),
    .result_o (result_o.source)
  );

  // Shadow copy of the register file.
  logic [CornerW-1:0] corner_q [4];
  logic [CntW-1:0]    cols_q, rows_q;
  logic [PitchW-1:0]  pitch_q;

  lens_pos_t   pending_q [$];
  int unsigned errors = 0;
  int unsigned n_results = 0;
  int unsigned n_inside = 0;
  int unsigned n_writes = 0;
  int unsigned stall_cnt = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clamp_cnt(logic [CntW-1:0] n);
    if (n < 2) return 2;
    if (n > MaxLenses) return MaxLenses;
    return longint'(n);
  endfunction

  function automatic longint coord_of(logic [CornerW-1:0] r, bit is_y);
    logic signed [CoordW-1:0] f;
    f = is_y ? r[CornerW-1:CoordW] : r[CoordW-1:0];
    return longint'(f);
  endfunction

  function automatic longint blend(bit is_y, longint c, longint r, longint w, longint h);
    longint num;
    num = (w - c) * (h - r) * coord_of(corner_q[0], is_y)
        + c * (h - r) * coord_of(corner_q[1], is_y)
        + (w - c) * r * coord_of(corner_q[2], is_y)
        + c * r * coord_of(corner_q[3], is_y);
    return floor_div(num, w * h);
  endfunction

  function automatic lens_pos_t locate(logic [IdxW-1:0] col, logic [IdxW-1:0] row);
    longint w, h, c, r, x, y;
    lens_pos_t p;
    w = clamp_cnt(cols_q) - 1;
    h = clamp_cnt(rows_q) - 1;
    c = (longint'(col) > w) ? w : longint'(col);
    r = (longint'(row) > h) ? h : longint'(row);
    x = blend(1'b0, c, r, w, h);
    y = blend(1'b1, c, r, w, h);
    if (r % 2 == 1) x += longint'(pitch_q);
    p = '0;
    if (x >= 0 && x <= longint'(SensorWidth - 1) << FracBits &&
        y >= 0 && y <= longint'(SensorHeight - 1) << FracBits) begin
      p.pcol = PixW'(x >> FracBits);
      p.prow = PixW'(y >> FracBits);
      p.fx   = x[FracBits-1:0];
      p.fy   = y[FracBits-1:0];
      p.ins  = 1'b1;
    end
    return p;
  endfunction

  // APB write; an index beyond the register list must be ignored by the block.
  task automatic reg_write(int unsigned idx, logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 8);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_writes++;
    case (idx)
      RegCornerTl, RegCornerTr, RegCornerBl, RegCornerBr: corner_q[idx] = val[CornerW-1:0];
      RegLensCols:  cols_q  = val[CntW-1:0];
      RegLensRows:  rows_q  = val[CntW-1:0];
      RegHalfPitch: pitch_q = val[PitchW-1:0];
      default: ;
    endcase
  endtask

  task automatic reg_check(reg_idx_e idx);
    logic [DataW-1:0] want;
    case (idx)
      RegLensCols:  want = DataW'(cols_q);
      RegLensRows:  want = DataW'(rows_q);
      RegHalfPitch: want = DataW'(pitch_q);
      default:      want = DataW'(corner_q[idx]);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'(int'(idx) * 8);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t: register %s read %h, expected %h", $time, idx.name(), prdata, want);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_corners(logic [CoordW-1:0] xl, logic [CoordW-1:0] xr,
                             logic [CoordW-1:0] yt, logic [CoordW-1:0] yb);
    reg_write(RegCornerTl, DataW'({yt, xl}));
    reg_write(RegCornerTr, DataW'({yt, xr}));
    reg_write(RegCornerBl, DataW'({yb, xl}));
    reg_write(RegCornerBr, DataW'({yb, xr}));
  endtask

  // Offer one word; the caller decides about the gap that follows.
  task automatic send_word(logic [IdxW-1:0] col, logic [IdxW-1:0] row, bit typed,
                           lens_pos_t pos, bit may_gap);
    pending_q.push_back(typed ? pos : locate(col, row));
    item_i.valid    <= 1'b1;
    item_i.lens_col <= col;
    item_i.lens_row <= row;
    @(posedge clk_i);
    while (!item_i.ready) @(posedge clk_i);
    if (may_gap && idle_en && $urandom_range(0, 3) == 0) begin
      item_i.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Let the pipeline empty before touching the registers.
  task automatic drain;
    item_i.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  function automatic logic [CoordW-1:0] rand_coord(int unsigned mode, bit is_y);
    logic [CoordW-1:0] v;
    case (mode)
      0: v = CoordW'($urandom_range(0, ((is_y ? SensorHeight : SensorWidth) - 1) << FracBits));
      1: v = CoordW'($urandom);
      2: v = {1'b0, {(CoordW-1){1'b1}}};
      default: v = {1'b1, {(CoordW-1){1'b0}}};
    endcase
    return v;
  endfunction

  function automatic logic [CntW-1:0] rand_count();
    case ($urandom_range(0, 7))
      0: return CntW'($urandom_range(0, 1));
      1: return CntW'(2);
      2: return CntW'(MaxLenses);
      3: return CntW'($urandom_range(MaxLenses + 1, 2047));
      4, 5: return CntW'($urandom_range(2, 16));
      default: return CntW'($urandom_range(2, MaxLenses));
    endcase
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned burst;
    int unsigned held;
    burst = 0;
    result_o.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        held = 0;
        result_o.ready <= 1'b0;
        while (held < HoldLen) begin
          @(posedge clk_i);
          held++;
        end
        hold_req = 1'b0;
        result_o.ready <= 1'b1;
      end else if (burst != 0) begin
        burst--;
        result_o.ready <= (burst == 0);
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 17);
        result_o.ready <= 1'b0;
      end else begin
        result_o.ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    lens_pos_t want;
    lens_pos_t got;
    if (rst_ni && result_o.valid && result_o.ready) begin
      got = '{result_o.pixel_col, result_o.pixel_row, result_o.frac_x, result_o.frac_y,
              result_o.inside_res};
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word %p", $time, got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.ins) n_inside++;
        if (got !== want) begin
          $display("%0t: position mismatch, expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere.
  always @(posedge clk_i) begin
    if ((item_i.valid && item_i.ready) || (result_o.valid && result_o.ready) || psel) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLim) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  localparam int unsigned XLast = (SensorWidth - 1) << FracBits;
  localparam int unsigned YLast = (SensorHeight - 1) << FracBits;

  // Step 0 runs at reset values, where every lens lands on the origin.
  // Step 1 puts the corners on the sensor edges; step 2 adds a one-LSB odd-row shift.
  // Step 3 uses the largest counts and pitch; step 4 the most extreme corners.
  lens_row_t dir_tbl [] = '{
    '{0, 10'd0,    10'd0,    1'b1, '{13'd0,    13'd0,    8'd0, 8'd0, 1'b1}},
    '{0, 10'd1023, 10'd1023, 1'b1, '{13'd0,    13'd0,    8'd0, 8'd0, 1'b1}},
    '{0, 10'd1,    10'd0,    1'b1, '{13'd0,    13'd0,    8'd0, 8'd0, 1'b1}},
    '{1, 10'd0,    10'd0,    1'b1, '{13'd0,    13'd0,    8'd0, 8'd0, 1'b1}},
    '{1, 10'd1,    10'd0,    1'b1, '{13'd7727, 13'd0,    8'd0, 8'd0, 1'b1}},
    '{1, 10'd0,    10'd1,    1'b1, '{13'd0,    13'd5367, 8'd0, 8'd0, 1'b1}},
    '{1, 10'd1,    10'd1,    1'b1, '{13'd7727, 13'd5367, 8'd0, 8'd0, 1'b1}},
    '{1, 10'd5,    10'd7,    1'b1, '{13'd7727, 13'd5367, 8'd0, 8'd0, 1'b1}},
    '{2, 10'd1,    10'd1,    1'b1, '{13'd0,    13'd0,    8'd0, 8'd0, 1'b0}},
    '{2, 10'd0,    10'd1,    1'b1, '{13'd0,    13'd5367, 8'd1, 8'd0, 1'b1}},
    '{2, 10'd1,    10'd0,    1'b1, '{13'd7727, 13'd0,    8'd0, 8'd0, 1'b1}},
    '{3, 10'd0,    10'd0,    1'b0, '0},
    '{3, 10'd511,  10'd511,  1'b0, '0},
    '{3, 10'd1023, 10'd0,    1'b0, '0},
    '{3, 10'd0,    10'd1023, 1'b0, '0},
    '{3, 10'd512,  10'd513,  1'b0, '0},
    '{3, 10'd1023, 10'd1023, 1'b0, '0},
    '{4, 10'd0,    10'd0,    1'b0, '0},
    '{4, 10'd1,    10'd1,    1'b0, '0},
    '{4, 10'd682,  10'd341,  1'b0, '0},
    '{4, 10'd1023, 10'd1023, 1'b0, '0}
  };

  initial begin
    int unsigned step;
    int unsigned n_items;
    int unsigned cmode;
    int unsigned ccnt, rcnt;
    logic [IdxW-1:0] col, row;
    rst_ni  = 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    item_i.valid    <= 1'b0;
    item_i.lens_col <= '0;
    item_i.lens_row <= '0;
    foreach (corner_q[i]) corner_q[i] = '0;
    cols_q  = CntW'(2);
    rows_q  = CntW'(2);
    pitch_q = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_check(RegCornerTl);
    reg_check(RegLensCols);

    step = 0;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].step != step) begin
        drain();
        step = dir_tbl[i].step;
        case (step)
          1: set_corners('0, CoordW'(XLast), '0, CoordW'(YLast));
          2: reg_write(RegHalfPitch, 64'd1);
          3: begin
            reg_write(RegLensCols, 64'd1024);
            reg_write(RegLensRows, 64'd1024);
            reg_write(RegHalfPitch, 64'hFFFF);
          end
          default: begin
            reg_write(RegCornerTl, {19'h7FFFF, 2'b01, {(CoordW-1){1'b1}}, 1'b0,
                                    {(CoordW-1){1'b1}}});
            reg_write(RegCornerTr, 64'h0000_0800_0020_0000);
            reg_write(RegCornerBl, '1);
            reg_write(RegCornerBr, 64'h0000_0000_0000_0000);
            reg_write(7, '1);
            reg_check(RegCornerTl);
            reg_check(RegHalfPitch);
          end
        endcase
      end
      send_word(dir_tbl[i].col, dir_tbl[i].row, dir_tbl[i].typed, dir_tbl[i].pos, 1'b1);
    end
    drain();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      cmode = (ph == 3) ? 2 : (ph == 4) ? 3 : ($urandom_range(0, 4) == 0) ? 1 : 0;
      set_corners(rand_coord(cmode, 1'b0), rand_coord(cmode, 1'b0),
                  rand_coord(cmode, 1'b1), rand_coord(cmode, 1'b1));
      if ($urandom_range(0, 1)) begin
        reg_write(RegCornerBr, DataW'({rand_coord(cmode, 1'b1), rand_coord(cmode, 1'b0)}));
      end
      reg_write(RegLensCols, DataW'(rand_count()));
      reg_write(RegLensRows, DataW'(rand_count()));
      reg_write(RegHalfPitch, (ph % 5 == 0) ? 64'h0 : (ph % 5 == 1) ? 64'hFFFF
                                            : DataW'($urandom_range(0, 4096)));
      reg_check(RegCornerBr);
      ccnt = 32'(clamp_cnt(cols_q));
      rcnt = 32'(clamp_cnt(rows_q));
      // Sender gaps and receiver stall bursts stop for the last phases and for some others.
      idle_en = (ph < NumPhases - 3) && (ph % 4 != 2);
      n_items = 60;
      if (ph == 6) begin
        hold_req = 1'b1;
        n_items = 150;
      end
      for (int unsigned k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          col = IdxW'($urandom);
          row = IdxW'($urandom);
        end else begin
          col = IdxW'($urandom_range(0, ccnt - 1));
          row = IdxW'($urandom_range(0, rcnt - 1));
        end
        send_word(col, row, 1'b0, '0, ph != 6);
      end
      drain();
    end

    $display("Covered %0d result words (%0d on sensor) and %0d register writes,",
             n_results, n_inside, n_writes);
    $display("with saturated counts and indices, odd-row shifts and a long output stall.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
